// ----- rtl/core/lpr_pkg.sv -----
// Shared types and constants for the line pixel rasterizer.
package lpr_pkg;
  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int NW = 2 * CW;
  localparam int EW = (DW > 14) ? DW : 14;
  localparam int AW = 30;
  localparam int CNTW = $clog2(NW) + 1;
  localparam logic [2:0] REG_PEN_COLOR = 3'd0;
  localparam logic [2:0] REG_X_RES = 3'd1;
  localparam logic [2:0] REG_Y_RES = 3'd2;
  localparam logic [2:0] REG_X_OFF = 3'd3;
  localparam logic [2:0] REG_Y_OFF = 3'd4;
  localparam logic [2:0] REG_BPP = 3'd5;
  localparam logic [2:0] REG_LINE_BYTES = 3'd6;
  localparam logic [2:0] REG_SCREEN_BYTES = 3'd7;
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_OFFSCREEN = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;
  localparam logic [1:0] PIXEL_ROOM = 2'd2;

  typedef struct packed {
    logic                 op;
    logic                 vert;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic [CW-1:0]        dx;
    logic signed [DW-1:0] dy;
    logic [CW-1:0]        send;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pen_color;
    logic [12:0] x_res;
    logic [12:0] y_res;
    logic [11:0] x_off;
    logic [11:0] y_off;
    logic [2:0]  bpp;
    logic [15:0] line_bytes;
    logic [29:0] screen_bytes;
  } cfg_t;
endpackage

// ----- rtl/core/lpr_front.sv -----
// Request decode: orders endpoints and derives step parameters.
module lpr_front (
  input  logic                         op,
  input  logic signed [lpr_pkg::CW-1:0] start_x,
  input  logic signed [lpr_pkg::CW-1:0] start_y,
  input  logic signed [lpr_pkg::CW-1:0] end_x,
  input  logic signed [lpr_pkg::CW-1:0] end_y,
  output lpr_pkg::cmd_t                cmd
);
  import lpr_pkg::*;

  logic signed [DW-1:0] ddx, ddy, ady;

  always_comb begin
    ddx = DW'(end_x) - DW'(start_x);
    ddy = DW'(end_y) - DW'(start_y);
    ady = ddy[DW-1] ? -ddy : ddy;
    cmd.op = op;
    if (start_x == end_x) begin
      cmd.vert = 1'b1;
      cmd.ox = start_x;
      cmd.oy = (start_y < end_y) ? start_y : end_y;
      cmd.dx = '0;
      cmd.dy = ady;
      cmd.send = ady[CW-1:0];
    end else if (start_x < end_x) begin
      cmd.vert = 1'b0;
      cmd.ox = start_x;
      cmd.oy = start_y;
      cmd.dx = ddx[CW-1:0];
      cmd.dy = ddy;
      cmd.send = ddx[CW-1:0];
    end else begin
      cmd.vert = 1'b0;
      cmd.ox = end_x;
      cmd.oy = end_y;
      cmd.dx = CW'(-ddx);
      cmd.dy = -ddy;
      cmd.send = CW'(-ddx);
    end
  end
endmodule

// ----- rtl/core/lpr_queue.sv -----
// Two-entry request queue between decode and pixel engine.
module lpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lpr_pkg::cmd_t pop_data
);
  import lpr_pkg::*;

  cmd_t        mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/lpr_back.sv -----
// Pixel engine: steps the line, divides for y, clips and addresses.
module lpr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  lpr_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  lpr_pkg::cmd_t                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          valid_res,
  output logic signed [lpr_pkg::CW-1:0] pixel_x,
  output logic signed [lpr_pkg::CW-1:0] pixel_y,
  output logic [lpr_pkg::AW-1:0]        byte_address,
  output logic [15:0]                   color,
  output logic [1:0]                    status,
  output logic                          last
);
  import lpr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_CLIP = 3'd3;
  localparam logic [2:0] S_ADDR = 3'd4;

  logic [2:0]           st;
  logic                 active, vert;
  logic [CW-1:0]        k, send, dx;
  logic signed [CW-1:0] ox, oy;
  logic signed [DW-1:0] dy;
  logic                 neg;
  logic [NW-1:0]        quot;
  logic [CW:0]          rem;
  logic [CNTW-1:0]      cnt;
  logic signed [DW-1:0] px, py;
  logic                 off;
  logic [16:0]          prod_x;
  logic [29:0]          prod_y;

  logic [CW-1:0]        dy_mag;
  logic [CW+1:0]        trial;
  logic signed [DW-1:0] qs;
  logic signed [EW-1:0] pxe, pye;
  logic [13:0]          pxo, pyo;
  logic [30:0]          loc;
  logic                 beyond;

  assign q_pop = (st == S_IDLE) && q_valid && !out_valid;

  always_comb begin
    dy_mag = dy[DW-1] ? CW'(-dy) : dy[CW-1:0];
    trial = {rem, quot[NW-1]} - {2'b00, dx};
    qs = {quot[DW-2:0], ~trial[CW+1]};
    pxe = EW'(px);
    pye = EW'(py);
    pxo = {1'b0, pxe[12:0]} + {2'b00, cfg.x_off};
    pyo = {1'b0, pye[12:0]} + {2'b00, cfg.y_off};
    loc = {14'd0, prod_x} + {1'b0, prod_y};
    beyond = ({1'b0, loc} + 32'(PIXEL_ROOM)) > {2'b00, cfg.screen_bytes};
  end

  always_ff @(posedge clk) begin
    case (st)
      S_MUL: begin
        neg <= dy[DW-1];
        quot <= NW'(k * dy_mag);
        rem <= '0;
        cnt <= '0;
        if (vert) begin
          px <= DW'(ox);
          py <= DW'(oy) + DW'({1'b0, k});
        end else begin
          px <= DW'(ox) + DW'({1'b0, k});
        end
      end
      S_DIV: begin
        if (!trial[CW+1]) begin
          rem <= trial[CW:0];
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[CW-1:0], quot[NW-1]};
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          py <= DW'(oy) + (neg ? -qs : qs);
        end
      end
      S_CLIP: begin
        off <= pxe < 0 || pxe >= $signed(EW'({1'b0, cfg.x_res})) ||
               pye < 0 || pye >= $signed(EW'({1'b0, cfg.y_res}));
        prod_x <= 17'(pxo * cfg.bpp);
        prod_y <= 30'(pyo * cfg.line_bytes);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      active <= 1'b0;
      vert <= 1'b0;
      k <= '0;
      send <= '0;
      ox <= '0;
      oy <= '0;
      dx <= '0;
      dy <= '0;
      out_valid <= 1'b0;
      valid_res <= 1'b0;
      pixel_x <= '0;
      pixel_y <= '0;
      byte_address <= '0;
      color <= '0;
      status <= ST_WRITTEN;
      last <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (q_pop) begin
            if (!q_data.op) begin
              active <= 1'b1;
              vert <= q_data.vert;
              k <= '0;
              send <= q_data.send;
              ox <= q_data.ox;
              oy <= q_data.oy;
              dx <= q_data.dx;
              dy <= q_data.dy;
              st <= S_MUL;
            end else if (active) begin
              st <= S_MUL;
            end else begin
              out_valid <= 1'b1;
              valid_res <= 1'b0;
              pixel_x <= '0;
              pixel_y <= '0;
              byte_address <= '0;
              color <= '0;
              status <= ST_WRITTEN;
              last <= 1'b0;
            end
          end
        end
        S_MUL: st <= vert ? S_CLIP : S_DIV;
        S_DIV: if (cnt == CNTW'(NW - 1)) st <= S_CLIP;
        S_CLIP: st <= S_ADDR;
        S_ADDR: begin
          out_valid <= 1'b1;
          valid_res <= 1'b1;
          pixel_x <= px[CW-1:0];
          pixel_y <= py[CW-1:0];
          if (off) begin
            status <= ST_OFFSCREEN;
            byte_address <= '0;
            color <= '0;
          end else if (beyond) begin
            status <= ST_BEYOND;
            byte_address <= '0;
            color <= '0;
          end else begin
            status <= ST_WRITTEN;
            byte_address <= loc[AW-1:0];
            color <= cfg.pen_color;
          end
          if (k >= send) begin
            last <= 1'b1;
            active <= 1'b0;
          end else begin
            last <= 1'b0;
            k <= k + 1'b1;
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/line_pixel_rasterizer.sv -----
// Top level of the line pixel rasterizer.
// Each request yields one result. A start request (op 0) loads the endpoints and
// returns the first pixel; each op 1 request returns the next pixel of the line.
// A pixel of a non-vertical line is presented after dequeue by one multiply,
// the bit-serial divider for y, then clip and address stages. Vertical-line
// pixels skip the divider; an op 1 request with no line active presents its
// zero result at the dequeue edge.
// The engine takes the next request only after its result is accepted.
// A two-entry queue lets requests be taken while the engine works.
module line_pixel_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [29:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic signed [lpr_pkg::CW-1:0] start_x,
  input  logic signed [lpr_pkg::CW-1:0] start_y,
  input  logic signed [lpr_pkg::CW-1:0] end_x,
  input  logic signed [lpr_pkg::CW-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          valid_res,
  output logic signed [lpr_pkg::CW-1:0] pixel_x,
  output logic signed [lpr_pkg::CW-1:0] pixel_y,
  output logic [lpr_pkg::AW-1:0]        byte_address,
  output logic [15:0]                   color,
  output logic [1:0]                    status,
  output logic                          last
);
  import lpr_pkg::*;

  cfg_t cfg;
  cmd_t dec_cmd, q_data;
  logic q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pen_color <= 16'd61770;
      cfg.x_res <= 13'd240;
      cfg.y_res <= 13'd320;
      cfg.x_off <= '0;
      cfg.y_off <= '0;
      cfg.bpp <= 3'd2;
      cfg.line_bytes <= 16'd480;
      cfg.screen_bytes <= 30'd153600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEN_COLOR: cfg.pen_color <= cfg_data[15:0];
        REG_X_RES: cfg.x_res <= cfg_data[12:0];
        REG_Y_RES: cfg.y_res <= cfg_data[12:0];
        REG_X_OFF: cfg.x_off <= cfg_data[11:0];
        REG_Y_OFF: cfg.y_off <= cfg_data[11:0];
        REG_BPP: cfg.bpp <= cfg_data[2:0];
        REG_LINE_BYTES: cfg.line_bytes <= cfg_data[15:0];
        REG_SCREEN_BYTES: cfg.screen_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  lpr_front u_front (
    .op(op), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cmd(dec_cmd)
  );

  lpr_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && in_ready), .push_data(dec_cmd),
    .full(q_full), .pop(q_pop), .not_empty(q_valid), .pop_data(q_data)
  );

  lpr_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .valid_res(valid_res), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .byte_address(byte_address), .color(color), .status(status), .last(last)
  );

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_WRITTEN |-> byte_address == '0 && color == '0)
    else $error("skipped pixel carries address or color");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> !last && status == ST_WRITTEN && pixel_x == '0)
    else $error("idle result not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_UNUSED)
    else $error("unused status code");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !in_ready)
    else $error("queue overrun");
endmodule

// ----- tb/line_pixel_rasterizer_checker.sv -----
// Checker for the line pixel rasterizer: predicts every pixel and compares results.
`timescale 1ns / 100ps
module line_pixel_rasterizer_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [29:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               valid_res,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  input  logic [29:0]        byte_address,
  input  logic [15:0]        color,
  input  logic [1:0]         status,
  input  logic               last,
  output int                 pending,
  output int                 checked,
  output int                 errors
);
  import lpr_pkg::*;

  typedef struct packed {
    logic        vld;
    logic [15:0] px;
    logic [15:0] py;
    logic [29:0] addr;
    logic [15:0] col;
    logic [1:0]  st;
    logic        lst;
  } pixel_t;

  pixel_t pixel_q[$];
  cfg_t   cfg;

  bit          active, vert;
  int unsigned pos, stop;
  longint      org_x, org_y, dlt_x, dlt_y;

  assign pending = pixel_q.size();

  function automatic pixel_t next_pixel(logic o, logic signed [15:0] x1, logic signed [15:0] y1,
                                        logic signed [15:0] x2, logic signed [15:0] y2);
    pixel_t r;
    longint px, py, loc;
    r = '0;
    if (!o) begin
      pos = 0;
      if (x1 == x2) begin
        vert = 1;
        org_x = x1;
        org_y = (y1 < y2) ? y1 : y2;
        dlt_x = 0;
        dlt_y = (y1 < y2) ? longint'(y2) - y1 : longint'(y1) - y2;
        stop = 32'(dlt_y);
      end else begin
        vert = 0;
        org_x = (x1 < x2) ? x1 : x2;
        org_y = (x1 < x2) ? y1 : y2;
        dlt_x = (x1 < x2) ? longint'(x2) - x1 : longint'(x1) - x2;
        dlt_y = (x1 < x2) ? longint'(y2) - y1 : longint'(y1) - y2;
        stop = 32'(dlt_x);
      end
      active = 1;
    end
    if (active) begin
      if (vert) begin
        px = org_x;
        py = org_y + pos;
      end else begin
        px = org_x + pos;
        py = org_y + (longint'(pos) * dlt_y) / dlt_x;
      end
      r.vld = 1;
      r.px = px[15:0];
      r.py = py[15:0];
      if (px < 0 || px > longint'(cfg.x_res) - 1 || py < 0 || py > longint'(cfg.y_res) - 1) begin
        r.st = ST_OFFSCREEN;
      end else begin
        loc = (px + cfg.x_off) * longint'(cfg.bpp) + (py + cfg.y_off) * longint'(cfg.line_bytes);
        if (loc > longint'(cfg.screen_bytes) - longint'(PIXEL_ROOM)) begin
          r.st = ST_BEYOND;
        end else begin
          r.st = ST_WRITTEN;
          r.addr = loc[29:0];
          r.col = cfg.pen_color;
        end
      end
      if (pos >= stop) begin
        r.lst = 1;
        active = 0;
      end else begin
        pos++;
      end
    end
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      cfg <= '{pen_color: 16'd61770, x_res: 13'd240, y_res: 13'd320, x_off: 12'd0, y_off: 12'd0,
               bpp: 3'd2, line_bytes: 16'd480, screen_bytes: 30'd153600};
      active = 0; vert = 0; pos = 0; stop = 0;
      org_x = 0; org_y = 0; dlt_x = 0; dlt_y = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PEN_COLOR:    cfg.pen_color <= cfg_data[15:0];
          REG_X_RES:        cfg.x_res <= cfg_data[12:0];
          REG_Y_RES:        cfg.y_res <= cfg_data[12:0];
          REG_X_OFF:        cfg.x_off <= cfg_data[11:0];
          REG_Y_OFF:        cfg.y_off <= cfg_data[11:0];
          REG_BPP:          cfg.bpp <= cfg_data[2:0];
          REG_LINE_BYTES:   cfg.line_bytes <= cfg_data[15:0];
          REG_SCREEN_BYTES: cfg.screen_bytes <= cfg_data[29:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pixel_q.push_back(next_pixel(op, start_x, start_y, end_x, end_y));
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          errors++;
        end else begin
          e = pixel_q.pop_front();
          checked++;
          if (valid_res !== e.vld) report("valid_res", valid_res, e.vld);
          if (pixel_x !== e.px) report("pixel_x", pixel_x, e.px);
          if (pixel_y !== e.py) report("pixel_y", pixel_y, e.py);
          if (byte_address !== e.addr) report("byte_address", byte_address, e.addr);
          if (color !== e.col) report("color", color, e.col);
          if (status !== e.st) report("status", status, e.st);
          if (last !== e.lst) report("last", last, e.lst);
        end
      end
    end
  end
endmodule

// ----- tb/tb.sv -----
// Testbench top: drives line requests and register settings, gives the verdict.
`timescale 1ns / 100ps
module tb;
  import lpr_pkg::*;

  logic clk, rst, cfg_we, in_valid, in_ready, op, out_valid, out_ready;
  logic [2:0] cfg_index;
  logic [29:0] cfg_data;
  logic signed [15:0] start_x, start_y, end_x, end_y, pixel_x, pixel_y;
  logic valid_res, last;
  logic [29:0] byte_address;
  logic [15:0] color;
  logic [1:0] status;
  int pending, checked, errors, requests, settings;
  bit no_gaps, choke_req;

  line_pixel_rasterizer uut (.*);
  line_pixel_rasterizer_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("line_pixel_rasterizer verification failed");
    $finish;
  end

  always begin
    @(negedge clk);
    if (choke_req) begin
      out_ready <= 0;
      repeat (400) @(negedge clk);
      choke_req = 0;
    end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
      out_ready <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      out_ready <= 1;
    end
  end

  task automatic send(logic o, int x1, int y1, int x2, int y2);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1;
    op <= o;
    start_x <= 16'(x1); start_y <= 16'(y1); end_x <= 16'(x2); end_y <= 16'(y2);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_regs(logic [29:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    settings++;
  endtask

  function automatic int coord(int lo, int hi);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 1) ? -32768 : 32767;
      default: return int'($urandom_range(0, hi - lo)) + lo;
    endcase
  endfunction

  task automatic random_lines(int n, int xr, int yr);
    int x1, y1, x2, y2, ticks;
    while (n > 0) begin
      x1 = coord(-20, xr);
      y1 = coord(-20, yr);
      case ($urandom_range(0, 5))
        0: x2 = x1;
        1: x2 = coord(-20, xr);
        default: x2 = x1 + int'($urandom_range(0, 20)) - 10;
      endcase
      y2 = ($urandom_range(0, 3) == 0) ? coord(-20, yr) : y1 + int'($urandom_range(0, 40)) - 20;
      x2 = $signed(16'(x2));
      y2 = $signed(16'(y2));
      if ($urandom_range(0, 9) == 0) begin
        send(1, $urandom, $urandom, $urandom, $urandom);
        n--;
      end
      send(0, x1, y1, x2, y2);
      ticks = $urandom_range(0, 14);
      repeat (ticks) send(1, $urandom, $urandom, $urandom, $urandom);
      n -= ticks + 1;
    end
  endtask

  initial begin
    logic [29:0] v[8];
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0; op = 0;
    start_x = 0; start_y = 0; end_x = 0; end_y = 0; out_ready = 0;
    no_gaps = 0; choke_req = 0; requests = 0; settings = 1;
    repeat (9) @(negedge clk);
    rst = 0;
    @(negedge clk);

    send(1, 0, 0, 0, 0);
    send(0, 5, 5, 5, 5);
    send(0, 10, 8, 10, 4);
    repeat (5) send(1, 0, 0, 0, 0);
    send(0, 20, 3, 12, 30);
    repeat (8) send(1, 0, 0, 0, 0);
    send(0, 0, 0, 3, 319);
    send(1, 0, 0, 0, 0);
    send(0, 238, 318, 241, 321);
    repeat (3) send(1, 0, 0, 0, 0);
    send(0, -32768, 32767, 32767, -32768);
    send(1, 0, 0, 0, 0);
    send(0, -1, -1, -1, -32768);
    random_lines(60, 260, 340);
    drain();

    v = '{30'hffff, 30'h1fff, 30'h1fff, 30'hfff, 30'hfff, 30'h7, 30'hffff, 30'h3fffffff};
    write_regs(v);
    choke_req = 1;
    random_lines(80, 8200, 8200);
    drain();

    v = '{30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0};
    write_regs(v);
    random_lines(40, 40, 40);
    drain();

    v = '{30'h1234, 30'd64, 30'd48, 30'd0, 30'd0, 30'd0, 30'd1, 30'd1};
    write_regs(v);
    random_lines(40, 80, 60);
    drain();

    v = '{30'h5a5a, 30'd100, 30'd80, 30'd7, 30'd3, 30'd4, 30'd400, 30'd20000};
    write_regs(v);
    random_lines(120, 120, 100);
    drain();

    v = '{30'hf14a, 30'd240, 30'd320, 30'd0, 30'd0, 30'd2, 30'd480, 30'd153600};
    write_regs(v);
    no_gaps = 1;
    random_lines(120, 260, 340);
    drain();

    $display("requests sent: %0d, pixels checked: %0d, register settings: %0d",
             requests, checked, settings);
    if (errors == 0)
      $display("line_pixel_rasterizer verification clean");
    else
      $display("line_pixel_rasterizer verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/lpr_pkg.sv
rtl/core/lpr_front.sv
rtl/core/lpr_queue.sv
rtl/core/lpr_back.sv
rtl/core/line_pixel_rasterizer.sv
tb/line_pixel_rasterizer_checker.sv
tb/tb.sv
